@@ rtl/lcs_pkg.sv @@
// ----------------------------------------------------------------------------
// lcs_pkg: shared types and constants of the LCS length engine
// Item structures, kind codes, controller states and the command bundle
// that the controller sends to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package lcs_pkg;

	localparam int MAX_LEN_DEF = 256;
	localparam int LCS_LEN_W   = 9;
	localparam int SYMBOL_W    = 8;
	localparam int KIND_W      = 2;

	typedef enum logic [KIND_W-1:0] {
		KIND_LOAD_A  = 2'd0,
		KIND_LOAD_B  = 2'd1,
		KIND_COMPUTE = 2'd2
	} kind_t;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [SYMBOL_W-1:0] symbol;
	} in_item_t;

	typedef struct packed {
		logic [LCS_LEN_W-1:0] lcs_length;
		logic                 overflow;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROW,
		ST_COL,
		ST_DRAIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load_a;
		logic load_b;
		logic row_start;
		logic cell_rd;
		logic first_row;
		logic first_col;
		logic last_cell;
		logic zero_res;
		logic push;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

@@ rtl/lcs_ram.sv @@
// ----------------------------------------------------------------------------
// lcs_ram: generic simple dual-port RAM
// One write port and one read port with registered read data that holds
// its value while no read is requested.
// ----------------------------------------------------------------------------
`default_nettype none

module lcs_ram #(
	parameter  int WIDTH = 8,
	parameter  int DEPTH = 256,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/lcs_ctrl.sv @@
// ----------------------------------------------------------------------------
// lcs_ctrl: controller of the LCS length engine
// Decodes input beats and sequences the row-by-column table walk.
// ----------------------------------------------------------------------------
`default_nettype none

module lcs_ctrl #(
	parameter  int MAX_LEN = lcs_pkg::MAX_LEN_DEF,
	localparam int AW      = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1,
	localparam int LW      = $clog2(MAX_LEN + 1)
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [lcs_pkg::KIND_W-1:0]  kind,
	input  wire logic [LW-1:0]               len_a,
	input  wire logic [LW-1:0]               len_b,
	input  wire lcs_pkg::status_t            status,
	output lcs_pkg::cmd_t                    cmd,
	output logic      [AW-1:0]               row_idx,
	output logic      [AW-1:0]               col_idx
);

	import lcs_pkg::*;

	state_t        state_q, state_d;
	logic [AW-1:0] row_q, row_d;
	logic [AW-1:0] col_q, col_d;
	logic          accept;
	logic          last_row;
	logic          last_col;

	assign accept   = in_valid && in_ready;
	assign last_row = (LW'(row_q) == len_a - LW'(1));
	assign last_col = (LW'(col_q) == len_b - LW'(1));
	assign row_idx  = row_q;
	assign col_idx  = col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q   <= '0;
			col_q   <= '0;
		end else begin
			state_q <= state_d;
			row_q   <= row_d;
			col_q   <= col_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		row_d    = row_q;
		col_d    = col_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (accept) begin
					unique case (kind)
						KIND_LOAD_A: begin
							cmd.load_a = 1'b1;
						end
						KIND_LOAD_B: begin
							cmd.load_b = 1'b1;
						end
						KIND_COMPUTE: begin
							row_d = '0;
							if (status.empty) begin
								cmd.zero_res = 1'b1;
								state_d      = ST_DONE;
							end else begin
								state_d = ST_ROW;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_ROW: begin
				cmd.row_start = 1'b1;
				col_d         = '0;
				state_d       = ST_COL;
			end
			ST_COL: begin
				cmd.cell_rd   = 1'b1;
				cmd.first_row = (row_q == '0);
				cmd.first_col = (col_q == '0);
				cmd.last_cell = last_row && last_col;
				if (last_col) begin
					if (last_row) begin
						state_d = ST_DRAIN;
					end else begin
						row_d   = row_q + AW'(1);
						state_d = ST_ROW;
					end
				end else begin
					col_d = col_q + AW'(1);
				end
			end
			ST_DRAIN: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (status.out_free) begin
					cmd.push = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/lcs_dp.sv @@
// ----------------------------------------------------------------------------
// lcs_dp: datapath of the LCS length engine
// String stores, lengths, the table row buffer, the one-cell compute stage
// and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lcs_dp #(
	parameter  int MAX_LEN = lcs_pkg::MAX_LEN_DEF,
	localparam int AW      = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1,
	localparam int LW      = $clog2(MAX_LEN + 1)
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [lcs_pkg::SYMBOL_W-1:0] symbol,
	input  wire lcs_pkg::cmd_t                cmd,
	input  wire logic [AW-1:0]                row_idx,
	input  wire logic [AW-1:0]                col_idx,
	output logic      [LW-1:0]                len_a,
	output logic      [LW-1:0]                len_b,
	output lcs_pkg::status_t                  status,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output lcs_pkg::out_item_t                out_data
);

	import lcs_pkg::*;

	logic [LW-1:0]       len_a_q;
	logic [LW-1:0]       len_b_q;
	logic                dropped_q;
	logic                wr_a;
	logic                wr_b;
	logic [SYMBOL_W-1:0] sym_a;
	logic [SYMBOL_W-1:0] sym_b;
	logic [LW-1:0]       row_rdata;

	logic                cell_vld_s1;
	logic                first_row_s1;
	logic                first_col_s1;
	logic                last_cell_s1;
	logic [AW-1:0]       col_s1;

	logic [LW-1:0]       left_q;
	logic [LW-1:0]       diag_q;
	logic [LW-1:0]       res_q;
	logic                out_valid_q;
	out_item_t           out_q;

	logic [LW-1:0]       up;
	logic [LW-1:0]       left;
	logic [LW-1:0]       diag;
	logic [LW-1:0]       cell_val;

	assign wr_a = cmd.load_a && (len_a_q < LW'(MAX_LEN));
	assign wr_b = cmd.load_b && (len_b_q < LW'(MAX_LEN));

	lcs_ram #(.WIDTH(SYMBOL_W), .DEPTH(MAX_LEN)) u_str_a (
		.clk   (clk),
		.we    (wr_a),
		.waddr (len_a_q[AW-1:0]),
		.wdata (symbol),
		.re    (cmd.row_start),
		.raddr (row_idx),
		.rdata (sym_a)
	);

	lcs_ram #(.WIDTH(SYMBOL_W), .DEPTH(MAX_LEN)) u_str_b (
		.clk   (clk),
		.we    (wr_b),
		.waddr (len_b_q[AW-1:0]),
		.wdata (symbol),
		.re    (cmd.cell_rd),
		.raddr (col_idx),
		.rdata (sym_b)
	);

	// Entry k of the row buffer holds table column k+1; column zero is always 0.
	lcs_ram #(.WIDTH(LW), .DEPTH(MAX_LEN)) u_row (
		.clk   (clk),
		.we    (cell_vld_s1),
		.waddr (col_s1),
		.wdata (cell_val),
		.re    (cmd.cell_rd),
		.raddr (col_idx),
		.rdata (row_rdata)
	);

	// The first row reads zeros instead of clearing the row buffer.
	assign up   = first_row_s1 ? '0 : row_rdata;
	assign left = first_col_s1 ? '0 : left_q;
	assign diag = first_col_s1 ? '0 : diag_q;

	always_comb begin
		if (sym_a == sym_b) begin
			cell_val = diag + LW'(1);
		end else if (up >= left) begin
			cell_val = up;
		end else begin
			cell_val = left;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_a_q      <= '0;
			len_b_q      <= '0;
			dropped_q    <= 1'b0;
			cell_vld_s1  <= 1'b0;
			first_row_s1 <= 1'b0;
			first_col_s1 <= 1'b0;
			last_cell_s1 <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (wr_a) begin
				len_a_q <= len_a_q + LW'(1);
			end
			if (wr_b) begin
				len_b_q <= len_b_q + LW'(1);
			end
			if ((cmd.load_a && !wr_a) || (cmd.load_b && !wr_b)) begin
				dropped_q <= 1'b1;
			end
			cell_vld_s1  <= cmd.cell_rd;
			first_row_s1 <= cmd.first_row;
			first_col_s1 <= cmd.first_col;
			last_cell_s1 <= cmd.last_cell;
			if (cmd.push) begin
				len_a_q     <= '0;
				len_b_q     <= '0;
				dropped_q   <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		col_s1 <= col_idx;
		if (cell_vld_s1) begin
			left_q <= cell_val;
			diag_q <= up;
		end
		if (cmd.zero_res) begin
			res_q <= '0;
		end else if (cell_vld_s1 && last_cell_s1) begin
			res_q <= cell_val;
		end
		if (cmd.push) begin
			out_q.lcs_length <= LCS_LEN_W'(res_q);
			out_q.overflow   <= dropped_q;
		end
	end

	assign len_a           = len_a_q;
	assign len_b           = len_b_q;
	assign status.empty    = (len_a_q == '0) || (len_b_q == '0);
	assign status.out_free = !out_valid_q || out_ready;
	assign out_valid       = out_valid_q;
	assign out_data        = out_q;

endmodule

`default_nettype wire

@@ rtl/lcs_length_engine.sv @@
// ----------------------------------------------------------------------------
// lcs_length_engine: longest-common-subsequence length of two byte strings
// Input beats load symbols into string A or B or start a compute; a compute
// returns one result beat with the LCS length and the overflow flag.
// ----------------------------------------------------------------------------
// Usage: each input beat carries a kind and a symbol. Kind 0 appends the
// symbol to string A, kind 1 to string B; a load gives no result. Loads
// beyond MAX_LEN symbols are dropped and flagged. Kind 2 starts the table
// walk, which visits one table cell per cycle within a row, with a
// row-start step before each row, over a shared compare-and-max unit with
// the row buffer in a RAM. The input is not ready during the walk. The
// result sits in an output register; loads keep being accepted while it
// waits, and a following compute waits at its end until the register is
// taken. After the result both strings are empty and the overflow flag is
// clear. Reset empties both strings, clears the flag and drops a result
// not yet taken; the string stores themselves are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module lcs_length_engine #(
	parameter int MAX_LEN = lcs_pkg::MAX_LEN_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire lcs_pkg::in_item_t  in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output lcs_pkg::out_item_t      out_data
);

	import lcs_pkg::*;

	localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int LW = $clog2(MAX_LEN + 1);

	cmd_t          cmd;
	status_t       status;
	logic [AW-1:0] row_idx;
	logic [AW-1:0] col_idx;
	logic [LW-1:0] len_a;
	logic [LW-1:0] len_b;

	lcs_ctrl #(.MAX_LEN(MAX_LEN)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.kind     (in_data.kind),
		.len_a    (len_a),
		.len_b    (len_b),
		.status   (status),
		.cmd      (cmd),
		.row_idx  (row_idx),
		.col_idx  (col_idx)
	);

	lcs_dp #(.MAX_LEN(MAX_LEN)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.symbol    (in_data.symbol),
		.cmd       (cmd),
		.row_idx   (row_idx),
		.col_idx   (col_idx),
		.len_a     (len_a),
		.len_b     (len_b),
		.status    (status),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire
